@@ sv/fee_pkg.sv @@
// ----------------------------------------------------------------------------
// fee_pkg
// Shared constants, types and controller/datapath links for the flash
// EEPROM emulation core.
// ----------------------------------------------------------------------------
package fee_pkg;

  localparam int PAGE_WORDS = 256;
  localparam int SLOT_COUNT = PAGE_WORDS - 1;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 8;
  localparam int VALUE_W = 24;
  localparam int WORD_W  = KEY_W + VALUE_W;

  localparam logic [KEY_W-1:0] RESERVED_KEY = {KEY_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_INIT  = 2'd2,
    KIND_RSVD  = 2'd3
  } fee_kind_t;

  typedef struct packed {
    logic take;
    logic start_scan;
    logic scan;
    logic wr;
    logic init;
    logic res_load;
    logic res_err;
    logic res_hit;
    logic publish;
  } fee_cmd_t;

  typedef struct packed {
    fee_kind_t kind;
    logic      in_fire;
    logic      key_rsvd;
    logic      empty;
    logic      full;
    logic      marked;
    logic      hit;
    logic      exhausted;
    logic      out_free;
  } fee_sts_t;

endpackage

@@ sv/fee_in_if.sv @@
// ----------------------------------------------------------------------------
// fee_in_if
// Request channel: operation kind, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface fee_in_if import fee_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);

endinterface

@@ sv/fee_out_if.sv @@
// ----------------------------------------------------------------------------
// fee_out_if
// Response channel: status and read value with valid/ready.
// ----------------------------------------------------------------------------
interface fee_out_if import fee_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               status;
  logic [VALUE_W-1:0] read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);

endinterface

@@ sv/fee_ram.sv @@
// ----------------------------------------------------------------------------
// fee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/fee_ctrl.sv @@
// ----------------------------------------------------------------------------
// fee_ctrl
// Sequencer: decodes each transaction, runs the downward read scan and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module fee_ctrl import fee_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fee_sts_t sts,
  output fee_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_fire) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESULT;
        unique case (sts.kind)
          KIND_READ: begin
            if (sts.key_rsvd || sts.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_err  = 1'b1;
            end else begin
              cmd.start_scan = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          KIND_WRITE: begin
            cmd.res_load = 1'b1;
            if (sts.key_rsvd || sts.full) begin
              cmd.res_err = 1'b1;
            end else begin
              cmd.wr = 1'b1;
            end
          end
          KIND_INIT: begin
            cmd.res_load = 1'b1;
            cmd.init     = !sts.marked;
          end
          KIND_RSVD: begin
            cmd.res_load = 1'b1;
            cmd.res_err  = 1'b1;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_err  = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        priority if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_hit  = 1'b1;
          state_nxt    = S_RESULT;
        end else if (sts.exhausted) begin
          cmd.res_load = 1'b1;
          cmd.res_err  = 1'b1;
          state_nxt    = S_RESULT;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/fee_dp.sv @@
// ----------------------------------------------------------------------------
// fee_dp
// Datapath: transaction capture, slot fill count, page mark, scan pointer,
// slot RAM, pending result and output register.
// ----------------------------------------------------------------------------
module fee_dp import fee_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  fee_in_if.sink   in_ch,
  fee_out_if.source out_ch,
  input  fee_cmd_t cmd,
  output fee_sts_t sts
);

  fee_kind_t          kind_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;

  logic [CNT_W-1:0]   cnt_r;
  logic               marked_r;
  logic [SLOT_AW-1:0] idx_r;
  logic               more_r;
  logic               rd_vld_r;

  logic               res_err_r;
  logic [VALUE_W-1:0] res_val_r;
  logic               out_vld_r;
  logic               out_err_r;
  logic [VALUE_W-1:0] out_val_r;

  logic [WORD_W-1:0]  rdata;
  logic [CNT_W-1:0]   cnt_dec;
  logic               fire;

  assign in_ch.ready = cmd.take;
  assign fire        = in_ch.valid && cmd.take;
  assign cnt_dec     = cnt_r - 1'b1;

  fee_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (cnt_r[SLOT_AW-1:0]),
    .wdata ({key_r, value_r}),
    .re    (cmd.scan),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r  <= fee_kind_t'(in_ch.kind);
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
    if (cmd.start_scan) begin
      idx_r <= cnt_dec[SLOT_AW-1:0];
    end else if (cmd.scan && more_r) begin
      idx_r <= idx_r - 1'b1;
    end
    if (cmd.res_load) begin
      res_err_r <= cmd.res_err;
      res_val_r <= cmd.res_hit ? rdata[VALUE_W-1:0] : '0;
    end
    if (cmd.publish) begin
      out_err_r <= res_err_r;
      out_val_r <= res_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      marked_r  <= 1'b0;
      more_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.init) begin
        cnt_r    <= '0;
        marked_r <= 1'b1;
      end else if (cmd.wr) begin
        cnt_r <= cnt_r + 1'b1;
      end
      rd_vld_r <= cmd.scan && more_r;
      if (cmd.start_scan) begin
        more_r <= 1'b1;
      end else if (cmd.scan && more_r) begin
        more_r <= (idx_r != '0);
      end
      if (cmd.publish) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = out_err_r;
  assign out_ch.read_value = out_val_r;

  always_comb begin
    sts           = '0;
    sts.kind      = kind_r;
    sts.in_fire   = fire;
    sts.key_rsvd  = (key_r == RESERVED_KEY);
    sts.empty     = (cnt_r == '0);
    sts.full      = (cnt_r == CNT_W'(SLOT_COUNT));
    sts.marked    = marked_r;
    sts.hit       = rd_vld_r && (rdata[WORD_W-1 -: KEY_W] == key_r);
    sts.exhausted = !more_r && !rd_vld_r;
    sts.out_free  = !out_vld_r || out_ch.ready;
  end

endmodule

@@ sv/flash_eeprom_emulation_core.sv @@
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_core
// Key/value store emulated on one append-only flash page.
//
// Request channel in_ch: kind (read, write, init), key, value. Response
// channel out_ch: one transaction per request with status (1 = error) and
// read_value. Both use valid/ready; a transaction moves when both are high.
// Writes append {key, value} at the fill count of the slot RAM in one step.
// Reads scan the written slots from the newest down, one RAM read per cycle,
// until a key match or until the oldest slot has been read. Every result
// passes through a pending result register to the output register. One
// request is in flight; in_ch.ready returns at the edge that loads the
// result into the output register, which holds it while out_ch.ready is
// low, so a stalled receiver delays only the next result. Reset clears the
// fill count and page mark; slots above the fill count are never read, so
// no clearing pass runs.
// ----------------------------------------------------------------------------
module flash_eeprom_emulation_core import fee_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fee_in_if.sink    in_ch,
  fee_out_if.source out_ch
);

  fee_cmd_t cmd;
  fee_sts_t sts;

  fee_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  fee_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

`ifndef ASSERT_OFF
  a_wr_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> !sts.full && !sts.key_rsvd)
    else $error("slot write issued on a full page or reserved key");

  a_hit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    sts.hit |-> $past(cmd.scan))
    else $error("scan hit without a preceding slot read");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second transaction accepted while one is in flight");

  a_publish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_ch.valid)
    else $error("published result not presented on out_ch");
`endif

endmodule
